// ----- rtl/core/srp_pkg.sv -----
`timescale 1ns / 1ps

package srp_pkg;

    // Widths of the fixed item and result fields
    localparam int unsigned DIM_W  = 13;
    localparam int unsigned SIZE_W = DIM_W + 1;    // item size plus two margins
    localparam int unsigned SUM_W  = DIM_W + 2;    // stored coordinate plus item size
    localparam int unsigned MRG_W  = 8;
    localparam int unsigned BIN_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_MAX_WIDTH  = 2'd0,
        CFG_BIN_MAX_HEIGHT = 2'd1,
        CFG_MARGIN         = 2'd2
    } cfg_idx_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_PLACED    = 2'd0,
        STAT_TOO_LARGE = 2'd1,
        STAT_NO_BIN    = 2'd2,
        STAT_CLEARED   = 2'd3
    } status_t;

    // How a bin takes an item
    typedef enum logic [1:0] {
        FIT_NONE = 2'd0,
        FIT_ROW  = 2'd1,
        FIT_NEW  = 2'd2
    } fit_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_CHECK = 3'd1,
        ST_SCAN  = 3'd2,
        ST_PLACE = 3'd3,
        ST_OPEN  = 3'd4,
        ST_FULL  = 3'd5
    } state_t;

    // Result and state update the datapath performs
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_BIG   = 3'd2,
        OP_FULL  = 3'd3,
        OP_PLACE = 3'd4,
        OP_OPEN  = 3'd5
    } op_t;

    // One bin's shelf state
    typedef struct packed {
        logic [DIM_W-1:0] cursor;
        logic [DIM_W-1:0] base;
        logic [DIM_W-1:0] used_h;
        logic [DIM_W-1:0] used_w;
    } bin_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;    // capture the input transaction
        logic start;    // rewind the bin scan
        logic scan;     // read the next bin entry
        op_t  op;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_clear;
        logic too_big;
        logic hit;
        logic exhausted;
        logic full;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/srp_ctrl.sv -----
`timescale 1ns / 1ps

module srp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  srp_pkg::dp_stat_t  stat,
    output srp_pkg::dp_cmd_t   cmd
);

    srp_pkg::state_t state_reg;
    srp_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence one item: check, scan bins when needed, then commit
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = srp_pkg::OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            srp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = srp_pkg::ST_CHECK;
                end
            end
            srp_pkg::ST_CHECK: begin
                if (stat.is_clear) begin
                    if (stat.out_free) begin
                        cmd.op     = srp_pkg::OP_CLEAR;
                        state_next = srp_pkg::ST_IDLE;
                    end
                end else if (stat.too_big) begin
                    if (stat.out_free) begin
                        cmd.op     = srp_pkg::OP_BIG;
                        state_next = srp_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.start  = 1'b1;
                    state_next = srp_pkg::ST_SCAN;
                end
            end
            srp_pkg::ST_SCAN: begin
                if (stat.hit) begin
                    state_next = srp_pkg::ST_PLACE;
                end else if (stat.exhausted) begin
                    state_next = stat.full ? srp_pkg::ST_FULL : srp_pkg::ST_OPEN;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            srp_pkg::ST_PLACE: begin
                if (stat.out_free) begin
                    cmd.op     = srp_pkg::OP_PLACE;
                    state_next = srp_pkg::ST_IDLE;
                end
            end
            srp_pkg::ST_OPEN: begin
                if (stat.out_free) begin
                    cmd.op     = srp_pkg::OP_OPEN;
                    state_next = srp_pkg::ST_IDLE;
                end
            end
            srp_pkg::ST_FULL: begin
                if (stat.out_free) begin
                    cmd.op     = srp_pkg::OP_FULL;
                    state_next = srp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/srp_datapath.sv -----
`timescale 1ns / 1ps

module srp_datapath #(
    parameter int unsigned NUM_BINS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srp_pkg::dp_cmd_t              cmd,
    output srp_pkg::dp_stat_t             stat,
    // item fields and limits
    input  logic                          mode,
    input  logic [srp_pkg::DIM_W-1:0]     item_width,
    input  logic [srp_pkg::DIM_W-1:0]     item_height,
    input  logic [srp_pkg::DIM_W-1:0]     bin_max_width,
    input  logic [srp_pkg::DIM_W-1:0]     bin_max_height,
    input  logic [srp_pkg::MRG_W-1:0]     margin,
    // result register
    output logic                          res_valid,
    input  logic                          res_ready,
    output srp_pkg::status_t              status,
    output logic [srp_pkg::BIN_W-1:0]     bin_index,
    output logic [srp_pkg::DIM_W-1:0]     pos_x,
    output logic [srp_pkg::DIM_W-1:0]     pos_y,
    output logic                          opened_bin,
    output logic [srp_pkg::DIM_W-1:0]     bin_used_width,
    output logic [srp_pkg::DIM_W-1:0]     bin_used_height
);

    // the scan pointer runs up to one past NUM_BINS
    localparam int unsigned CNT_W = $clog2(NUM_BINS + 2);
    localparam int unsigned IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int unsigned DW    = srp_pkg::DIM_W;
    localparam int unsigned SW    = srp_pkg::SIZE_W;
    localparam int unsigned UW    = srp_pkg::SUM_W;

    // Bin state memory, undefined until a bin is opened
    srp_pkg::bin_entry_t mem [NUM_BINS];

    logic                 mode_reg;
    logic [SW-1:0]        s_reg;
    logic [SW-1:0]        t_reg;
    logic [CNT_W-1:0]     open_bins_reg;
    logic [CNT_W-1:0]     addr_reg;
    logic                 live_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    srp_pkg::bin_entry_t  rd_data_reg;

    logic                 res_valid_reg;
    srp_pkg::status_t     status_reg;
    logic [srp_pkg::BIN_W-1:0] bin_reg;
    logic [DW-1:0]        px_reg;
    logic [DW-1:0]        py_reg;
    logic                 opened_reg;
    logic [DW-1:0]        uw_reg;
    logic [DW-1:0]        uh_reg;

    logic                 out_free;
    logic                 is_open;
    srp_pkg::bin_entry_t  ent;
    srp_pkg::fit_t        fit;
    srp_pkg::fit_t        fit_use;
    logic [UW-1:0]        base_top;
    logic [UW-1:0]        cur_end;
    logic [UW-1:0]        new_top;
    srp_pkg::bin_entry_t  upd;
    logic [DW-1:0]        px;
    logic [DW-1:0]        py;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W+srp_pkg::BIN_W-1:0] wr_idx_ext;
    logic [DW-1:0]        new_cursor;

    assign out_free = !res_valid_reg || res_ready;
    assign is_open  = (cmd.op == srp_pkg::OP_OPEN);
    assign ent      = is_open ? '0 : rd_data_reg;

    // Shelf fit test of the held entry
    always_comb begin
        base_top = {2'b00, ent.base} + {1'b0, t_reg};
        cur_end  = {2'b00, ent.cursor} + {1'b0, s_reg};
        new_top  = {2'b00, ent.used_h} + {1'b0, t_reg};
        if (base_top > {2'b00, bin_max_height}) begin
            fit = srp_pkg::FIT_NONE;
        end else if (cur_end <= {2'b00, bin_max_width}) begin
            fit = srp_pkg::FIT_ROW;
        end else if (new_top <= {2'b00, bin_max_height}) begin
            fit = srp_pkg::FIT_NEW;
        end else begin
            fit = srp_pkg::FIT_NONE;
        end
    end

    // Updated entry and placement for the chosen bin
    always_comb begin
        fit_use = is_open ? srp_pkg::FIT_ROW : fit;
        upd     = ent;
        if (fit_use == srp_pkg::FIT_NEW) begin
            upd.base   = ent.used_h;
            px         = {{(DW-srp_pkg::MRG_W){1'b0}}, margin};
            py         = ent.used_h + {{(DW-srp_pkg::MRG_W){1'b0}}, margin};
            new_cursor = s_reg[DW-1:0];
            upd.used_h = new_top[DW-1:0];
        end else begin
            px         = ent.cursor + {{(DW-srp_pkg::MRG_W){1'b0}}, margin};
            py         = ent.base + {{(DW-srp_pkg::MRG_W){1'b0}}, margin};
            new_cursor = cur_end[DW-1:0];
            if (base_top > {2'b00, ent.used_h}) begin
                upd.used_h = base_top[DW-1:0];
            end
        end
        upd.cursor = new_cursor;
        if (new_cursor > ent.used_w) begin
            upd.used_w = new_cursor;
        end
    end

    assign wr_idx     = is_open ? open_bins_reg[IDX_W-1:0] : rd_idx_reg;
    assign wr_idx_ext = {{srp_pkg::BIN_W{1'b0}}, wr_idx};

    // Report to the controller
    always_comb begin
        stat.is_clear  = mode_reg;
        stat.too_big   = (s_reg > {1'b0, bin_max_width}) ||
                         (t_reg > {1'b0, bin_max_height});
        stat.hit       = live_reg && (fit != srp_pkg::FIT_NONE);
        stat.exhausted = !live_reg && (addr_reg >= open_bins_reg);
        stat.full      = (open_bins_reg == CNT_W'(NUM_BINS));
        stat.out_free  = out_free;
    end

    // Capture the item with its padded sizes
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            mode_reg <= mode;
            s_reg    <= {1'b0, item_width} + {{(SW-srp_pkg::MRG_W-1){1'b0}}, margin, 1'b0};
            t_reg    <= {1'b0, item_height} + {{(SW-srp_pkg::MRG_W-1){1'b0}}, margin, 1'b0};
        end
    end

    // Read one entry per scan cycle, write back the chosen bin
    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
            rd_idx_reg  <= addr_reg[IDX_W-1:0];
        end
        if (cmd.op == srp_pkg::OP_PLACE || cmd.op == srp_pkg::OP_OPEN) begin
            mem[wr_idx] <= upd;
        end
    end

    // Scan pointer and open bin count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_bins_reg <= '0;
            addr_reg      <= '0;
            live_reg      <= 1'b0;
        end else begin
            if (cmd.start) begin
                addr_reg <= '0;
                live_reg <= 1'b0;
            end else if (cmd.scan) begin
                addr_reg <= addr_reg + CNT_W'(1);
                live_reg <= (addr_reg < open_bins_reg);
            end
            if (cmd.op == srp_pkg::OP_CLEAR) begin
                open_bins_reg <= '0;
            end else if (is_open) begin
                open_bins_reg <= open_bins_reg + CNT_W'(1);
            end
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (cmd.op != srp_pkg::OP_NONE) begin
            res_valid_reg <= 1'b1;
        end else if (res_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.op != srp_pkg::OP_NONE) begin
            bin_reg    <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            opened_reg <= 1'b0;
            uw_reg     <= '0;
            uh_reg     <= '0;
            case (cmd.op)
                srp_pkg::OP_CLEAR: status_reg <= srp_pkg::STAT_CLEARED;
                srp_pkg::OP_BIG:   status_reg <= srp_pkg::STAT_TOO_LARGE;
                srp_pkg::OP_FULL:  status_reg <= srp_pkg::STAT_NO_BIN;
                default: begin
                    status_reg <= srp_pkg::STAT_PLACED;
                    bin_reg    <= wr_idx_ext[srp_pkg::BIN_W-1:0];
                    px_reg     <= px;
                    py_reg     <= py;
                    opened_reg <= is_open;
                    uw_reg     <= upd.used_w;
                    uh_reg     <= upd.used_h;
                end
            endcase
        end
    end

    assign res_valid       = res_valid_reg;
    assign status          = status_reg;
    assign bin_index       = bin_reg;
    assign pos_x           = px_reg;
    assign pos_y           = py_reg;
    assign opened_bin      = opened_reg;
    assign bin_used_width  = uw_reg;
    assign bin_used_height = uh_reg;

endmodule

// ----- rtl/core/shelf_rectangle_packer.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Contents
// s_       in         tuser: mode; tdata: item_width, item_height
// m_       out        tuser: status; tdata: bin_index, pos_x, pos_y, opened_bin,
//                     bin_used_width, bin_used_height
// cfg_     in         write-only limits: bin_max_width, bin_max_height, margin
//
// An item that fits an open bin is checked, then the scan reads the bin memory one entry
// per cycle until a bin takes it, and the placement is committed. An item that opens a
// bin or finds every bin full is committed once the scan has passed all open bins.
// Clear and oversize requests are committed from the check. One item is in flight at a time.
// Reset empties all bins; bin entries are written when a bin opens, no clearing pass.
// A stalled m_ side holds the finished transaction; the block waits before committing.

module shelf_rectangle_packer #(
    parameter int unsigned NUM_BINS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [12:0] item_width, [25:13] item_height
    input  logic        s_tuser,    // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [3:0] bin_index, [16:4] pos_x, [29:17] pos_y,
                                    // [30] opened_bin, [43:31] bin_used_width,
                                    // [56:44] bin_used_height
    output logic [1:0]  m_tuser,    // [1:0] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata
);

    localparam int unsigned DW = srp_pkg::DIM_W;

    logic [DW-1:0]              max_w_reg;
    logic [DW-1:0]              max_h_reg;
    logic [srp_pkg::MRG_W-1:0]  margin_reg;

    srp_pkg::dp_cmd_t   cmd;
    srp_pkg::dp_stat_t  stat;
    srp_pkg::status_t   status;
    logic [srp_pkg::BIN_W-1:0] bin_index;
    logic [DW-1:0]      pos_x;
    logic [DW-1:0]      pos_y;
    logic               opened_bin;
    logic [DW-1:0]      used_w;
    logic [DW-1:0]      used_h;

    // Write the limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_w_reg  <= DW'(1024);
            max_h_reg  <= DW'(1024);
            margin_reg <= srp_pkg::MRG_W'(2);
        end else if (cfg_we) begin
            unique case (srp_pkg::cfg_idx_t'(cfg_index))
                srp_pkg::CFG_BIN_MAX_WIDTH:  max_w_reg  <= cfg_wdata;
                srp_pkg::CFG_BIN_MAX_HEIGHT: max_h_reg  <= cfg_wdata;
                srp_pkg::CFG_MARGIN:         margin_reg <= cfg_wdata[srp_pkg::MRG_W-1:0];
                default: ;
            endcase
        end
    end

    srp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srp_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .mode            (s_tuser),
        .item_width      (s_tdata[12:0]),
        .item_height     (s_tdata[25:13]),
        .bin_max_width   (max_w_reg),
        .bin_max_height  (max_h_reg),
        .margin          (margin_reg),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .status          (status),
        .bin_index       (bin_index),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .opened_bin      (opened_bin),
        .bin_used_width  (used_w),
        .bin_used_height (used_h)
    );

    // Pack the result transaction
    assign m_tuser = status;
    assign m_tdata = {7'd0, used_h, used_w, opened_bin, pos_y, pos_x, bin_index};

`ifndef SYNTHESIS
    // A result is committed only when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op != srp_pkg::OP_NONE) |-> stat.out_free)
        else $error("result committed while output register is blocked");

    // A committed result shows on the master side in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op != srp_pkg::OP_NONE) |=> m_tvalid)
        else $error("committed result not presented");

    // No second item is taken while one is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // The bin scan never advances while a fit or exhaustion is reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> !(stat.hit || stat.exhausted))
        else $error("scan advanced past a decision");
`endif

endmodule
